// File: hdl/npq_pkg.sv
// shared types, constants and helpers of the nearest palette quantiser
// used by npq_cfg, npq_cell and nearest_palette_quantizer; depends on nothing
package npq_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int CHAIN_DEPTH     = 2 * PALETTE_ENTRIES;
	localparam int FLIGHT_W        = $clog2(CHAIN_DEPTH + 1);

	localparam int COLOR_W   = 8;
	localparam int INDEX_W   = 8;
	localparam int SQ_W      = 2 * COLOR_W;
	localparam int DIST_W    = SQ_W + 2;
	localparam int ALPHA_W   = 8;
	localparam int LIMIT_W   = 9;

	localparam logic [LIMIT_W-1:0] ALPHA_LIMIT_RESET = LIMIT_W'(128);

	// largest distance code, above any real sum of three squares
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// request codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_ALPHA_LIMIT = '0;

	typedef struct packed {
		logic               vld;
		logic               transp;
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
		logic [DIST_W-1:0]  best_dist;
		logic [INDEX_W-1:0] best_idx;
	} pixel_t;

	typedef struct packed {
		pixel_t          pix;
		logic [SQ_W-1:0] sq_r;
		logic [SQ_W-1:0] sq_g;
		logic [SQ_W-1:0] sq_b;
	} sq_stage_t;

	typedef struct packed {
		logic               en;
		logic               ent_valid;
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
	} wr_t;

	function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
			input logic [COLOR_W-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// File: hdl/nearest_palette_quantizer.sv
// Nearest palette quantiser. Each palette entry lives in its own cell of a compare chain;
// a pixel walks the chain two register stages per cell (squares, then sum and compare) and
// leaves through an output register. Pixels stream in at one per cycle for as long as the
// result side keeps taking them; a full output register stalls the whole chain. A palette
// write is taken only once the chain holds no pixel, so a write after a burst of pixels
// waits for the chain to drain. Reset clears every entry to invalid at once; there is no
// clearing pass. Alpha below alpha_limit (apb byte address 0) gives a transparent result
// with index 0; with no valid entry the index is 0.
// depends on npq_pkg, npq_cfg and npq_cell
module nearest_palette_quantizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [npq_pkg::PADDR_W-1:0]   paddr,
	input  logic [npq_pkg::PDATA_W-1:0]   pwdata,
	output logic [npq_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  logic                          cmd,
	input  logic [npq_pkg::INDEX_W-1:0]   entry_index,
	input  logic                          entry_valid,
	input  logic [npq_pkg::COLOR_W-1:0]   red,
	input  logic [npq_pkg::COLOR_W-1:0]   green,
	input  logic [npq_pkg::COLOR_W-1:0]   blue,
	input  logic [npq_pkg::ALPHA_W-1:0]   alpha,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          transparent,
	output logic [npq_pkg::INDEX_W-1:0]   color_index
);

	logic [npq_pkg::LIMIT_W-1:0]  alpha_limit;
	logic [npq_pkg::FLIGHT_W-1:0] flight_q;
	logic                         stall, adv, take, take_pixel, chain_done;
	logic                         res_valid_q, transparent_q;
	logic [npq_pkg::INDEX_W-1:0]  color_index_q;
	npq_pkg::wr_t                 wr;
	npq_pkg::pixel_t              link [0:npq_pkg::PALETTE_ENTRIES];

	npq_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.alpha_limit (alpha_limit)
	);

	assign stall = res_valid_q && !res_ready;
	assign adv   = !stall;

	// pixels need a free output path, writes need an empty chain
	assign pix_ready  = (cmd == npq_pkg::CMD_PIXEL) ? !stall : (flight_q == '0);
	assign take       = pix_valid && pix_ready;
	assign take_pixel = take && (cmd == npq_pkg::CMD_PIXEL);

	always_comb begin
		wr           = '0;
		wr.en        = take && (cmd == npq_pkg::CMD_WRITE);
		wr.ent_valid = entry_valid;
		wr.r         = red;
		wr.g         = green;
		wr.b         = blue;
	end

	always_comb begin
		link[0]           = '0;
		link[0].vld       = take_pixel;
		link[0].transp    = npq_pkg::LIMIT_W'(alpha) < alpha_limit;
		link[0].r         = red;
		link[0].g         = green;
		link[0].b         = blue;
		link[0].best_dist = npq_pkg::DIST_MAX;
		link[0].best_idx  = '0;
	end

	for (genvar i = 0; i < npq_pkg::PALETTE_ENTRIES; i++) begin : g_cell
		npq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.wr         (wr),
			.wr_sel     (entry_index == npq_pkg::INDEX_W'(i)),
			.cell_index (npq_pkg::INDEX_W'(i)),
			.pix_in     (link[i]),
			.pix_out    (link[i+1])
		);
	end

	assign chain_done = adv && link[npq_pkg::PALETTE_ENTRIES].vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			flight_q <= flight_q + npq_pkg::FLIGHT_W'(take_pixel)
				- npq_pkg::FLIGHT_W'(chain_done);
			if (adv) begin
				res_valid_q <= link[npq_pkg::PALETTE_ENTRIES].vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			transparent_q <= link[npq_pkg::PALETTE_ENTRIES].transp;
			color_index_q <= link[npq_pkg::PALETTE_ENTRIES].transp ? '0
				: link[npq_pkg::PALETTE_ENTRIES].best_idx;
		end
	end

	assign res_valid   = res_valid_q;
	assign transparent = transparent_q;
	assign color_index = color_index_q;

	a_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flight_q <= npq_pkg::FLIGHT_W'(npq_pkg::CHAIN_DEPTH))
		else $error("chain occupancy beyond its depth");

	a_empty_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(flight_q == '0) |-> !link[npq_pkg::PALETTE_ENTRIES].vld)
		else $error("pixel leaves an empty chain");

	a_write_empty: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (flight_q == '0) && !take_pixel)
		else $error("palette write while pixels in flight");

	a_transp_index: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && transparent) |-> (color_index == '0))
		else $error("transparent result with non-zero index");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!res_valid_q ##1 res_valid_q) |-> ($past(flight_q) != '0))
		else $error("result without a pixel in the chain");

endmodule

// File: hdl/npq_cfg.sv
// apb register block holding the alpha limit
// depends on npq_pkg
module npq_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [npq_pkg::PADDR_W-1:0]   paddr,
	input  logic [npq_pkg::PDATA_W-1:0]   pwdata,
	output logic [npq_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [npq_pkg::LIMIT_W-1:0]   alpha_limit
);

	logic [npq_pkg::LIMIT_W-1:0] alpha_limit_q;
	logic                        hit;

	assign hit    = (paddr[npq_pkg::PADDR_W-1:2] == npq_pkg::REG_ALPHA_LIMIT);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_limit_q <= npq_pkg::ALPHA_LIMIT_RESET;
		end else if (psel && penable && pwrite && hit) begin
			alpha_limit_q <= pwdata[npq_pkg::LIMIT_W-1:0];
		end
	end

	assign prdata = hit ? npq_pkg::PDATA_W'(alpha_limit_q) : '0;
	assign alpha_limit = alpha_limit_q;

endmodule

// File: hdl/npq_cell.sv
// one palette entry of the compare chain: squares in the first stage,
// sum and best-so-far update in the second; depends on npq_pkg
module npq_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  npq_pkg::wr_t                wr,
	input  logic                        wr_sel,
	input  logic [npq_pkg::INDEX_W-1:0] cell_index,
	input  npq_pkg::pixel_t             pix_in,
	output npq_pkg::pixel_t             pix_out
);

	logic [npq_pkg::COLOR_W-1:0] r_q, g_q, b_q;
	logic                        ent_valid_q;

	npq_pkg::sq_stage_t st_s1, st_next;
	npq_pkg::pixel_t    pix_s2, pix_next;
	logic               vld_s1, vld_s2;
	logic [npq_pkg::COLOR_W-1:0] dr, dg, db;
	logic [npq_pkg::DIST_W-1:0]  sum_sq;
	logic                        hit;

	// entry storage; writes only arrive while the chain is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
		end else if (wr.en && wr_sel) begin
			ent_valid_q <= wr.ent_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr_sel) begin
			r_q <= wr.r;
			g_q <= wr.g;
			b_q <= wr.b;
		end
	end

	always_comb begin
		dr = npq_pkg::abs_diff(pix_in.r, r_q);
		dg = npq_pkg::abs_diff(pix_in.g, g_q);
		db = npq_pkg::abs_diff(pix_in.b, b_q);
		st_next      = '0;
		st_next.pix  = pix_in;
		st_next.sq_r = dr * dr;
		st_next.sq_g = dg * dg;
		st_next.sq_b = db * db;
	end

	always_comb begin
		sum_sq = npq_pkg::DIST_W'(st_s1.sq_r) + npq_pkg::DIST_W'(st_s1.sq_g)
			+ npq_pkg::DIST_W'(st_s1.sq_b);
		// strict compare keeps the lowest index on a tie
		hit = ent_valid_q && !st_s1.pix.transp && (sum_sq < st_s1.pix.best_dist);
		pix_next = st_s1.pix;
		pix_next.vld = vld_s1;
		if (hit) begin
			pix_next.best_dist = sum_sq;
			pix_next.best_idx  = cell_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix_in.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1  <= st_next;
			pix_s2 <= pix_next;
		end
	end

	always_comb begin
		pix_out     = pix_s2;
		pix_out.vld = vld_s2;
	end

endmodule

// File: test/nearest_palette_quantizer_test.sv
`timescale 1ns / 1ps
// self-checking bench for nearest_palette_quantizer: predicts the palette index of every pixel
// and checks the result port against it, with apb writes of the alpha limit between phases
// depends on npq_pkg and the quantiser rtl
module nearest_palette_quantizer_test;

	localparam int PALETTE_ENTRIES = npq_pkg::PALETTE_ENTRIES;
	localparam int COLOR_W         = npq_pkg::COLOR_W;
	localparam int INDEX_W         = npq_pkg::INDEX_W;
	localparam int ALPHA_W         = npq_pkg::ALPHA_W;
	localparam int LIMIT_W         = npq_pkg::LIMIT_W;
	localparam int PADDR_W         = npq_pkg::PADDR_W;
	localparam int PDATA_W         = npq_pkg::PDATA_W;
	localparam logic CMD_WRITE     = npq_pkg::CMD_WRITE;
	localparam logic CMD_PIXEL     = npq_pkg::CMD_PIXEL;
	localparam logic [LIMIT_W-1:0] ALPHA_LIMIT_RESET = npq_pkg::ALPHA_LIMIT_RESET;

	localparam int CHAIN_LATENCY = npq_pkg::CHAIN_DEPTH + 1;
	localparam int SETTLE_CYCLES = CHAIN_LATENCY + 16;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam logic [PADDR_W-1:0] LIMIT_ADDR = {npq_pkg::REG_ALPHA_LIMIT, 2'b00};

	typedef struct packed {
		logic               cmd;
		logic [INDEX_W-1:0] entry_index;
		logic               entry_valid;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [ALPHA_W-1:0] alpha;
	} pix_req_t;

	typedef struct packed {
		logic               transparent;
		logic [INDEX_W-1:0] color_index;
	} quant_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               pix_valid;
	logic               pix_ready;
	logic               cmd;
	logic [INDEX_W-1:0] entry_index;
	logic               entry_valid;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic [ALPHA_W-1:0] alpha;
	logic               res_valid;
	logic               res_ready;
	logic               transparent;
	logic [INDEX_W-1:0] color_index;

	nearest_palette_quantizer i_dut (.*);

	// own copy of the palette and the limit
	logic [3*COLOR_W-1:0] palette_color [PALETTE_ENTRIES];
	logic                 palette_live  [PALETTE_ENTRIES];
	logic [LIMIT_W-1:0]   alpha_threshold;

	quant_result_t pending_results[$];

	int tx_idle_pct;
	int rx_idle_pct;
	int fail_count;
	int writes_sent;
	int pixels_sent;
	int transparent_count;
	int results_checked;
	int limits_set;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic quant_result_t quantise(input pix_req_t rq);
		quant_result_t res;
		int            best_dist;
		int            sq_sum;
		int            dr;
		int            dg;
		int            db;
		res.transparent = 1'b0;
		res.color_index = '0;
		if ({1'b0, rq.alpha} < alpha_threshold) begin
			res.transparent = 1'b1;
			return res;
		end
		best_dist = 32'h7fff_ffff;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			if (palette_live[i]) begin
				dr = int'(rq.red) - int'(palette_color[i][23:16]);
				dg = int'(rq.green) - int'(palette_color[i][15:8]);
				db = int'(rq.blue) - int'(palette_color[i][7:0]);
				sq_sum = dr * dr + dg * dg + db * db;
				// strict compare keeps the lowest index on a tie
				if (sq_sum < best_dist) begin
					best_dist = sq_sum;
					res.color_index = INDEX_W'(i);
				end
			end
		end
		return res;
	endfunction

	function automatic pix_req_t make_pixel(input logic [COLOR_W-1:0] r,
			input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b,
			input logic [ALPHA_W-1:0] a);
		pix_req_t rq;
		rq.cmd         = CMD_PIXEL;
		rq.entry_index = INDEX_W'($urandom_range(255));
		rq.entry_valid = 1'($urandom_range(1));
		rq.red         = r;
		rq.green       = g;
		rq.blue        = b;
		rq.alpha       = a;
		return rq;
	endfunction

	function automatic pix_req_t make_write(input logic [INDEX_W-1:0] idx, input logic live,
			input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] b);
		pix_req_t rq;
		rq.cmd         = CMD_WRITE;
		rq.entry_index = idx;
		rq.entry_valid = live;
		rq.red         = r;
		rq.green       = g;
		rq.blue        = b;
		rq.alpha       = ALPHA_W'($urandom_range(255));
		return rq;
	endfunction

	// coarse levels make duplicate colours and equal distances common
	function automatic logic [COLOR_W-1:0] pick_level();
		if ($urandom_range(1))
			return COLOR_W'($urandom_range(255));
		case ($urandom_range(4))
			0: return COLOR_W'(8'h00);
			1: return COLOR_W'(8'h40);
			2: return COLOR_W'(8'h80);
			3: return COLOR_W'(8'hc0);
			default: return COLOR_W'(8'hff);
		endcase
	endfunction

	function automatic logic [LIMIT_W-1:0] pick_limit();
		case ($urandom_range(5))
			0: return LIMIT_W'(0);
			1: return LIMIT_W'(256);
			2: return LIMIT_W'(255);
			3: return LIMIT_W'(1);
			default: return LIMIT_W'($urandom_range(256));
		endcase
	endfunction

	function automatic pix_req_t random_write();
		logic [INDEX_W-1:0] idx;
		// half the writes hit a small corner of the palette so entries get overwritten
		idx = $urandom_range(1) ? INDEX_W'($urandom_range(15)) : INDEX_W'($urandom_range(255));
		return make_write(idx, $urandom_range(99) < 80, pick_level(), pick_level(), pick_level());
	endfunction

	function automatic pix_req_t random_pixel();
		logic [ALPHA_W-1:0] a;
		a = ($urandom_range(3) == 0) ? ALPHA_W'(255) : ALPHA_W'($urandom_range(255));
		return make_pixel(pick_level(), pick_level(), pick_level(), a);
	endfunction

	task automatic send_request(input pix_req_t rq);
		pix_valid   <= 1'b1;
		cmd         <= rq.cmd;
		entry_index <= rq.entry_index;
		entry_valid <= rq.entry_valid;
		red         <= rq.red;
		green       <= rq.green;
		blue        <= rq.blue;
		alpha       <= rq.alpha;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
		if (rq.cmd == CMD_WRITE) begin
			writes_sent++;
			if (int'(rq.entry_index) < PALETTE_ENTRIES) begin
				palette_color[rq.entry_index] = {rq.red, rq.green, rq.blue};
				palette_live[rq.entry_index]  = rq.entry_valid;
			end
		end else begin
			pixels_sent++;
			pending_results.insert(pending_results.size(), quantise(rq));
			if (pending_results[$].transparent)
				transparent_count++;
		end
		// each idle cycle is drawn on its own, so the idle share matches the percentage
		if ($urandom_range(99) < tx_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_alpha_limit(input logic [LIMIT_W-1:0] value);
		drain_results();
		// the chain is empty after the last result; a palette write never enters the chain
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIMIT_ADDR;
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		alpha_threshold = value;
		limits_set++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== PDATA_W'(value)) begin
			$error("alpha_limit read back: expected %0d, actual %0d", value, prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_empty_palette();
		// nothing valid after reset, default limit
		send_request(make_pixel(8'hff, 8'hff, 8'hff, 8'd127));
		send_request(make_pixel(8'h00, 8'h00, 8'h00, 8'd128));
		send_request(make_pixel(8'h55, 8'haa, 8'h55, 8'd0));
		send_request(make_pixel(8'h12, 8'h34, 8'h56, 8'd255));
	endtask

	task automatic test_nearest_search();
		send_request(make_write(8'd0, 1'b1, 8'h00, 8'h00, 8'h00));
		send_request(make_write(8'd255, 1'b1, 8'hff, 8'hff, 8'hff));
		send_request(make_write(8'd7, 1'b1, 8'h80, 8'h80, 8'h80));
		send_request(make_write(8'd3, 1'b1, 8'h80, 8'h80, 8'h80));
		send_request(make_write(8'd128, 1'b0, 8'h12, 8'h34, 8'h56));
		send_request(make_pixel(8'hff, 8'hff, 8'hff, 8'd255));
		send_request(make_pixel(8'h00, 8'h00, 8'h00, 8'd255));
		// duplicate colour at 3 and 7, then a pixel halfway between 0 and 3
		send_request(make_pixel(8'h80, 8'h80, 8'h80, 8'd255));
		send_request(make_pixel(8'h40, 8'h40, 8'h40, 8'd255));
		send_request(make_pixel(8'h7f, 8'h7f, 8'h7f, 8'd200));
		send_request(make_pixel(8'hff, 8'h00, 8'h00, 8'd255));
		send_request(make_pixel(8'h12, 8'h34, 8'h56, 8'd255));
		// drop entry 3 so its twin takes over
		send_request(make_write(8'd3, 1'b0, 8'h80, 8'h80, 8'h80));
		send_request(make_pixel(8'h80, 8'h80, 8'h80, 8'd255));
	endtask

	task automatic test_alpha_limits();
		set_alpha_limit(LIMIT_W'(0));
		send_request(make_pixel(8'h20, 8'h20, 8'h20, 8'd0));
		send_request(make_pixel(8'hf0, 8'h10, 8'h80, 8'd1));
		set_alpha_limit(LIMIT_W'(256));
		send_request(make_pixel(8'h20, 8'h20, 8'h20, 8'd255));
		send_request(make_pixel(8'hf0, 8'h10, 8'h80, 8'd0));
		set_alpha_limit(LIMIT_W'(255));
		send_request(make_pixel(8'h90, 8'h90, 8'h90, 8'd254));
		send_request(make_pixel(8'h90, 8'h90, 8'h90, 8'd255));
		set_alpha_limit(LIMIT_W'(1));
		send_request(make_pixel(8'h01, 8'h02, 8'h03, 8'd0));
		send_request(make_pixel(8'h01, 8'h02, 8'h03, 8'd1));
		set_alpha_limit(ALPHA_LIMIT_RESET);
	endtask

	task automatic test_random_traffic(input int item_count, input int tx_pct, input int rx_pct);
		int sent;
		int burst;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < item_count) begin
			if ($urandom_range(99) < 85) begin
				// palette load, then a stream of pixels through the chain
				burst = $urandom_range(1, 8);
				repeat (burst) send_request(random_write());
				sent += burst;
				burst = $urandom_range(8, 40);
				repeat (burst) send_request(random_pixel());
				sent += burst;
			end else begin
				repeat (4) send_request($urandom_range(1) ? random_write() : random_pixel());
				sent += 4;
			end
			if ($urandom_range(99) < 6)
				drain_results();
			else if ($urandom_range(99) < 4)
				set_alpha_limit(pick_limit());
		end
	endtask

	always @(posedge clk) begin : result_check
		quant_result_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					$error("unrequested result: transparent %0b color_index %0d",
						transparent, color_index);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					if (transparent !== want.transparent) begin
						$error("transparent: expected %0b, actual %0b",
							want.transparent, transparent);
						fail_count++;
					end
					if (color_index !== want.color_index) begin
						$error("color_index: expected %0d, actual %0d",
							want.color_index, color_index);
						fail_count++;
					end
				end
			end
			res_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		pix_valid   <= 1'b0;
		cmd         <= CMD_PIXEL;
		entry_index <= '0;
		entry_valid <= 1'b0;
		red         <= '0;
		green       <= '0;
		blue        <= '0;
		alpha       <= '0;
		res_ready   <= 1'b0;
		cycle_count = 0;
		fail_count = 0;
		writes_sent = 0;
		pixels_sent = 0;
		transparent_count = 0;
		results_checked = 0;
		limits_set = 0;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			palette_color[i] = '0;
			palette_live[i]  = 1'b0;
		end
		alpha_threshold = ALPHA_LIMIT_RESET;
		tx_idle_pct = 11;
		rx_idle_pct = 79;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_palette();
		test_nearest_search();
		test_alpha_limits();
		test_random_traffic(384, 11, 79);
		test_random_traffic(383, 79, 11);
		test_random_traffic(383, 0, 0);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d palette writes and %0d pixels, %0d of them transparent",
			writes_sent, pixels_sent, transparent_count);
		$display("checked %0d results over %0d alpha limit settings, %0d mismatches",
			results_checked, limits_set, fail_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
